FILE: hdl/gqtl_pkg.sv
// Package: shared types, constants and command codes for the glyph quad text layout block.
`default_nettype none
package gqtl_pkg;
   localparam int GLYPH_SLOTS         = 256;
   localparam int TAB_SPACES_DEFAULT  = 4;

   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_PLACE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_PIXEL_SCALE    = 3'd0,
      REG_TEXT_SCALE     = 3'd1,
      REG_LINE_SPACING   = 3'd2,
      REG_TEXTURE_WIDTH  = 3'd3,
      REG_TEXTURE_HEIGHT = 3'd4,
      REG_TEXT_COLOR     = 3'd5
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_MUL3, ST_DIV_DW, ST_DIV_ADV,
      ST_DIV_UL, ST_DIV_UR, ST_DIV_VT, ST_DIV_VB, ST_EMIT
   } state_type;

   typedef struct packed {
      logic        start;
      logic [39:0] dividend;
      logic [23:0] divisor;
   } div_req_type;
endpackage
`default_nettype wire

FILE: hdl/gqtl_div.sv
// Divider: restoring unsigned divide, one quotient bit per cycle.
`default_nettype none
module gqtl_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gqtl_pkg::div_req_type req,
   output logic                      done,
   output logic [39:0]               quotient
);
   logic [39:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [24:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[23:0], quo_ff[39]};
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = 6'd40;
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift one dividend bit into the partial remainder, subtract if it fits
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("divider done without a running division");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !done_ff)
      else $error("divider done while still running");
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff != 6'd0)
      else $error("divider running with zero count");
`endif
endmodule
`default_nettype wire

FILE: hdl/glyph_quad_text_layout.sv
// Top level: glyph atlas table memory, pen state and quad layout sequencer.
`default_nettype none
// Glyph quad text layout. Commands enter on req_ when start is high and busy
// is low: a load writes one glyph entry and a start sets the pen, both with
// busy never raised. A place reads the glyph entry from the table memory and,
// for a loaded glyph other than a space or tab, runs six 40-step divisions on
// one shared restoring divider: quad width, pen advance, then four texture
// coordinates. A space or tab with a loaded space glyph runs only the
// pen advance division, a newline only moves the pen down and back to zero,
// and an unknown glyph (or a space or tab without a space glyph) is dropped.
// Busy stays high until a place ends, so no command is taken meanwhile. The
// quad appears on the rsp_ ports for exactly one cycle, marked by rsp_valid;
// the receiver cannot stall it, so take each transfer when it shows.
// Configuration is written through the csr_ channel, always ready, and should
// be changed only while idle. The table holds one valid bit per slot in
// flip-flops, cleared at reset; no clearing pass is needed.
module glyph_quad_text_layout #(
   parameter int TAB_SPACES  = gqtl_pkg::TAB_SPACES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [11:0] req_atlas_x,
   input  wire logic [11:0] req_atlas_y,
   input  wire logic [11:0] req_cell_width,
   input  wire logic [11:0] req_cell_height,
   input  wire logic [11:0] req_advance_texels,
   input  wire logic [15:0] req_start_x,
   input  wire logic [15:0] req_start_y,
   output logic             rsp_valid,
   output logic [7:0]       rsp_glyph_code,
   output logic [23:0]      rsp_left_x,
   output logic [23:0]      rsp_right_x,
   output logic [23:0]      rsp_top_y,
   output logic [23:0]      rsp_bottom_y,
   output logic [16:0]      rsp_u_left,
   output logic [16:0]      rsp_u_right,
   output logic [16:0]      rsp_v_top,
   output logic [16:0]      rsp_v_bottom,
   output logic [31:0]      rsp_quad_color,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam int SLOT_BITS = $clog2(gqtl_pkg::GLYPH_SLOTS);
   localparam int TAB_BITS  = $clog2(TAB_SPACES + 1);

   // configuration registers
   logic [15:0] pscale_ff, tscale_ff, lspace_ff;
   logic [12:0] twidth_ff, theight_ff;
   logic [31:0] color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pscale_ff  <= 16'd4096;
         tscale_ff  <= 16'd256;
         lspace_ff  <= 16'd0;
         twidth_ff  <= 13'd256;
         theight_ff <= 13'd256;
         color_ff   <= 32'hFFFF_FFFF;
      end else if (csr_valid && csr_ready) begin
         case (gqtl_pkg::reg_type'(csr_index))
            gqtl_pkg::REG_PIXEL_SCALE:    pscale_ff  <= csr_data[15:0];
            gqtl_pkg::REG_TEXT_SCALE:     tscale_ff  <= csr_data[15:0];
            gqtl_pkg::REG_LINE_SPACING:   lspace_ff  <= csr_data[15:0];
            gqtl_pkg::REG_TEXTURE_WIDTH:  twidth_ff  <= csr_data[12:0];
            gqtl_pkg::REG_TEXTURE_HEIGHT: theight_ff <= csr_data[12:0];
            gqtl_pkg::REG_TEXT_COLOR:     color_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // glyph table: {x, y, w, h, adv}, 60 bits, plus valid flops
   logic [59:0]            table_mem [gqtl_pkg::GLYPH_SLOTS];
   logic [gqtl_pkg::GLYPH_SLOTS-1:0] valid_ff;
   logic [59:0]            rd_data_ff;
   logic                   rd_valid_ff;
   logic                   mem_we;
   logic [SLOT_BITS-1:0]   mem_waddr, mem_raddr;
   logic [59:0]            mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
      rd_data_ff  <= table_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) valid_ff[mem_waddr] <= 1'b1;
         rd_valid_ff <= valid_ff[mem_raddr];
      end
   end

   // sequencer state
   gqtl_pkg::state_type state_ff, state_in;
   logic [15:0] penx_ff, penx_in, peny_ff, peny_in;
   logic [7:0]  code_ff, code_in;
   logic [11:0] gx_ff, gx_in, gy_ff, gy_in, gw_ff, gw_in, gh_ff, gh_in, gadv_ff, gadv_in;
   logic [31:0] ps_ff, ps_in;          // P*S
   logic [39:0] prod_ff, prod_in;      // scratch product
   logic [23:0] dw_ff, dw_in;
   logic [16:0] ul_ff, ul_in, ur_ff, ur_in, vt_ff, vt_in;
   logic        out_ff, out_in;
   logic [16:0] vb_ff, vb_in;
   logic        space_ff, space_in;     // placing a space or tab
   gqtl_pkg::div_req_type dreq;
   logic        ddone;
   logic [39:0] dquo;
   logic [11:0] gh_nz;
   logic [12:0] tw_nz, th_nz;
   logic [39:0] adv_num;                // P*S*adv / 256, divided later by 256*h

   gqtl_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quotient(dquo));

   function automatic logic [16:0] sat17(input logic [39:0] q);
      sat17 = (q > 40'd65536) ? 17'd65536 : q[16:0];
   endfunction

   assign gh_nz = (gh_ff == 12'd0) ? 12'd1 : gh_ff;
   assign tw_nz = (twidth_ff == 13'd0) ? 13'd1 : twidth_ff;
   assign th_nz = (theight_ff == 13'd0) ? 13'd1 : theight_ff;
   assign adv_num = 40'(({12'd0, ps_ff} * {32'd0, gadv_ff}) >> 8);

   always_comb begin
      state_in  = state_ff;
      penx_in   = penx_ff;
      peny_in   = peny_ff;
      code_in   = code_ff;
      gx_in     = gx_ff;
      gy_in     = gy_ff;
      gw_in     = gw_ff;
      gh_in     = gh_ff;
      gadv_in   = gadv_ff;
      ps_in     = ps_ff;
      prod_in   = prod_ff;
      dw_in     = dw_ff;
      ul_in     = ul_ff;
      ur_in     = ur_ff;
      vt_in     = vt_ff;
      vb_in     = vb_ff;
      out_in    = 1'b0;
      space_in  = space_ff;
      mem_we    = 1'b0;
      mem_waddr = req_char_code[SLOT_BITS-1:0];
      mem_wdata = {req_atlas_x, req_atlas_y, req_cell_width, req_cell_height,
                   req_advance_texels};
      mem_raddr = code_ff[SLOT_BITS-1:0];
      dreq      = '0;
      case (state_ff)
         gqtl_pkg::ST_IDLE: begin
            if (start) begin
               code_in = req_char_code;
               case (gqtl_pkg::cmd_type'(req_command))
                  gqtl_pkg::CMD_LOAD: mem_we = 1'b1;
                  gqtl_pkg::CMD_START: begin
                     penx_in = req_start_x;
                     peny_in = req_start_y;
                  end
                  gqtl_pkg::CMD_PLACE: begin
                     space_in = (req_char_code == gqtl_pkg::CH_SPACE) ||
                                (req_char_code == gqtl_pkg::CH_TAB);
                     // space and tab both read the space glyph slot
                     code_in  = (req_char_code == gqtl_pkg::CH_TAB) ?
                                gqtl_pkg::CH_SPACE : req_char_code;
                     // remember a tab in bit 0 of the saved code
                     if (req_char_code == gqtl_pkg::CH_TAB) code_in = 8'd33;
                     if (req_char_code == gqtl_pkg::CH_NEWLINE) state_in = gqtl_pkg::ST_MUL1;
                     else state_in = gqtl_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         gqtl_pkg::ST_READ: begin
            // issue the table read; data and valid bit land for MUL1
            if (space_ff) mem_raddr = gqtl_pkg::CH_SPACE[SLOT_BITS-1:0];
            state_in = gqtl_pkg::ST_MUL1;
            if (space_ff) code_in = code_ff; // hold tab mark
         end
         gqtl_pkg::ST_MUL1: begin
            if (code_ff == gqtl_pkg::CH_NEWLINE && !space_ff) begin
               prod_in  = {24'd0, pscale_ff} * {23'd0, 17'd256 + {1'b0, lspace_ff}};
               state_in = gqtl_pkg::ST_MUL2;
            end else if (!rd_valid_ff) begin
               state_in = gqtl_pkg::ST_IDLE;
            end else begin
               {gx_in, gy_in, gw_in, gh_in, gadv_in} = rd_data_ff;
               ps_in    = {16'd0, pscale_ff} * {16'd0, tscale_ff};
               state_in = gqtl_pkg::ST_MUL2;
            end
         end
         gqtl_pkg::ST_MUL2: begin
            if (code_ff == gqtl_pkg::CH_NEWLINE && !space_ff) begin
               // P*(256+L) fits 33 bits; times S into 49, keep bits 48:24
               prod_in = 40'(({16'd0, prod_ff[32:0]} * {33'd0, tscale_ff}) >> 24);
               state_in = gqtl_pkg::ST_MUL3;
            end else begin
               // P*S*w fits 44 bits; drop the low 8 here, divide by h later
               prod_in  = 40'(({12'd0, ps_ff} * {32'd0, gw_ff}) >> 8);
               state_in = gqtl_pkg::ST_MUL3;
            end
         end
         gqtl_pkg::ST_MUL3: begin
            if (code_ff == gqtl_pkg::CH_NEWLINE && !space_ff) begin
               penx_in  = '0;
               peny_in  = peny_ff + prod_ff[15:0];
               state_in = gqtl_pkg::ST_IDLE;
            end else if (space_ff) begin
               dreq = '{start: 1'b1, dividend: adv_num, divisor: {4'd0, gh_nz, 8'd0}};
               state_in = gqtl_pkg::ST_DIV_ADV;
            end else begin
               dreq = '{start: 1'b1, dividend: prod_ff, divisor: {12'd0, gh_nz}};
               state_in = gqtl_pkg::ST_DIV_DW;
            end
         end
         gqtl_pkg::ST_DIV_DW: begin
            if (ddone) begin
               dw_in = dquo[23:0];
               dreq  = '{start: 1'b1, dividend: adv_num, divisor: {4'd0, gh_nz, 8'd0}};
               state_in = gqtl_pkg::ST_DIV_ADV;
            end
         end
         gqtl_pkg::ST_DIV_ADV: begin
            if (ddone) begin
               if (space_ff) begin
                  // tab multiplies the space advance
                  if (code_ff == 8'd33)
                     penx_in = penx_ff + 16'(dquo[15:0] * TAB_BITS'(TAB_SPACES));
                  else
                     penx_in = penx_ff + dquo[15:0];
                  state_in = gqtl_pkg::ST_IDLE;
               end else begin
                  prod_in = dquo;
                  dreq = '{start: 1'b1, dividend: {12'd0, gx_ff, 16'd0},
                           divisor: {11'd0, tw_nz}};
                  state_in = gqtl_pkg::ST_DIV_UL;
               end
            end
         end
         gqtl_pkg::ST_DIV_UL: begin
            if (ddone) begin
               ul_in = sat17(dquo);
               dreq = '{start: 1'b1, dividend: {11'd0, {1'b0, gx_ff} + {1'b0, gw_ff}, 16'd0},
                        divisor: {11'd0, tw_nz}};
               state_in = gqtl_pkg::ST_DIV_UR;
            end
         end
         gqtl_pkg::ST_DIV_UR: begin
            if (ddone) begin
               ur_in = sat17(dquo);
               dreq = '{start: 1'b1, dividend: {12'd0, gy_ff, 16'd0},
                        divisor: {11'd0, th_nz}};
               state_in = gqtl_pkg::ST_DIV_VT;
            end
         end
         gqtl_pkg::ST_DIV_VT: begin
            if (ddone) begin
               vt_in = sat17(dquo);
               dreq = '{start: 1'b1, dividend: {11'd0, {1'b0, gy_ff} + {1'b0, gh_ff}, 16'd0},
                        divisor: {11'd0, th_nz}};
               state_in = gqtl_pkg::ST_DIV_VB;
            end
         end
         gqtl_pkg::ST_DIV_VB: begin
            if (ddone) begin
               vb_in    = sat17(dquo);
               out_in   = 1'b1;
               state_in = gqtl_pkg::ST_EMIT;
            end
         end
         gqtl_pkg::ST_EMIT: begin
            // quad is on the ports this cycle; advance the pen behind it
            penx_in  = penx_ff + prod_ff[15:0];
            state_in = gqtl_pkg::ST_IDLE;
         end
         default: state_in = gqtl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      gw_ff    <= gw_in;
      gh_ff    <= gh_in;
      gadv_ff  <= gadv_in;
      ps_ff    <= ps_in;
      prod_ff  <= prod_in;
      dw_ff    <= dw_in;
      ul_ff    <= ul_in;
      ur_ff    <= ur_in;
      vt_ff    <= vt_in;
      vb_ff    <= vb_in;
      space_ff <= space_in;
      if (reset) begin
         state_ff <= gqtl_pkg::ST_IDLE;
         penx_ff  <= '0;
         peny_ff  <= '0;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         penx_ff  <= penx_in;
         peny_ff  <= peny_in;
         out_ff   <= out_in;
      end
   end

   assign busy           = (state_ff != gqtl_pkg::ST_IDLE);
   assign rsp_valid      = out_ff;
   assign rsp_glyph_code = code_ff;
   assign rsp_left_x     = {penx_ff, 8'd0};
   assign rsp_right_x    = {penx_ff, 8'd0} + dw_ff;
   assign rsp_top_y      = {peny_ff, 8'd0};
   assign rsp_bottom_y   = {peny_ff, 8'd0} + ps_ff[31:8];
   assign rsp_u_left     = ul_ff;
   assign rsp_u_right    = ur_ff;
   assign rsp_v_top      = vt_ff;
   assign rsp_v_bottom   = vb_ff;
   assign rsp_quad_color = color_ff;

`ifndef SYNTHESIS
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == gqtl_pkg::ST_EMIT)
      else $error("result strobe outside emit state");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == gqtl_pkg::CMD_PLACE) |=> busy)
      else $error("place command did not raise busy");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == gqtl_pkg::ST_EMIT |=> state_ff == gqtl_pkg::ST_IDLE)
      else $error("emit state did not return to idle");
`endif
endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the glyph quad text layout block: directed and random text against a glyph model.
`default_nettype none
module testbench;

   typedef struct {
      logic [7:0]  code;
      logic [23:0] lx, rx, ty, by;
      logic [16:0] ul, ur, vt, vb;
      logic [31:0] color;
   } quad_type;

   typedef struct {
      bit          ok;
      logic [11:0] gx, gy, gw, gh, adv;
   } glyph_type;

   logic clock = 0, reset = 1, start = 0, busy;
   logic [1:0]  req_command = 0;
   logic [7:0]  req_char_code = 0;
   logic [11:0] req_atlas_x = 0, req_atlas_y = 0, req_cell_width = 0;
   logic [11:0] req_cell_height = 1, req_advance_texels = 0;
   logic [15:0] req_start_x = 0, req_start_y = 0;
   logic        rsp_valid;
   logic [7:0]  rsp_glyph_code;
   logic [23:0] rsp_left_x, rsp_right_x, rsp_top_y, rsp_bottom_y;
   logic [16:0] rsp_u_left, rsp_u_right, rsp_v_top, rsp_v_bottom;
   logic [31:0] rsp_quad_color;
   logic        csr_valid = 0, csr_ready;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   glyph_quad_text_layout uut (.*);

   initial forever #1 clock = ~clock;

   // model state
   glyph_type   atlas [256];
   logic [15:0] pen_x, pen_y;
   longint unsigned pix_scale, txt_scale, line_gap, tex_w, tex_h;
   logic [31:0] color;
   quad_type    pending_quads [$];
   int          failures = 0;
   longint      cycles = 0;

   function automatic longint unsigned nz(longint unsigned v);
      return v == 0 ? 1 : v;
   endfunction

   function automatic logic [16:0] tex_coord(longint unsigned texel, longint unsigned size);
      longint unsigned q;
      q = (texel << 16) / nz(size);
      return q > 65536 ? 17'd65536 : q[16:0];
   endfunction

   function automatic logic [15:0] advance_of(glyph_type g);
      longint unsigned num;
      num = longint'(g.adv) * pix_scale * txt_scale;
      return 16'(num / (nz(g.gh) << 16));
   endfunction

   task automatic predict_layout(gqtl_pkg::cmd_type cmd, logic [7:0] code,
                                 logic [11:0] ax, ay, cw, ch, adv, logic [15:0] sx, sy);
      quad_type q;
      longint unsigned ps, dw, a;
      case (cmd)
         gqtl_pkg::CMD_LOAD: atlas[code] = '{1'b1, ax, ay, cw, ch, adv};
         gqtl_pkg::CMD_START: begin
            pen_x = sx; pen_y = sy;
         end
         gqtl_pkg::CMD_PLACE: begin
            if (code == gqtl_pkg::CH_SPACE || code == gqtl_pkg::CH_TAB) begin
               a = atlas[gqtl_pkg::CH_SPACE].ok ? advance_of(atlas[gqtl_pkg::CH_SPACE]) : 0;
               if (code == gqtl_pkg::CH_TAB) a = a * gqtl_pkg::TAB_SPACES_DEFAULT;
               pen_x = 16'(pen_x + a);
            end else if (code == gqtl_pkg::CH_NEWLINE) begin
               pen_x = 0;
               pen_y = 16'(pen_y + ((pix_scale * (256 + line_gap) * txt_scale) >> 24));
            end else if (atlas[code].ok) begin
               ps = pix_scale * txt_scale;
               dw = (ps * atlas[code].gw) / (nz(atlas[code].gh) << 8);
               q.code = code;
               q.lx = {pen_x, 8'd0};
               q.ty = {pen_y, 8'd0};
               q.rx = 24'({pen_x, 8'd0} + dw);
               q.by = 24'({pen_y, 8'd0} + (ps >> 8));
               q.ul = tex_coord(atlas[code].gx, tex_w);
               q.ur = tex_coord(longint'(atlas[code].gx) + atlas[code].gw, tex_w);
               q.vt = tex_coord(atlas[code].gy, tex_h);
               q.vb = tex_coord(longint'(atlas[code].gy) + atlas[code].gh, tex_h);
               q.color = color;
               pending_quads.push_back(q);
               pen_x = 16'(pen_x + advance_of(atlas[code]));
            end
         end
         default: ;
      endcase
   endtask

   // check each quad at the rising edge that ends its cycle
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (pending_quads.size() == 0) begin
            $error("unexpected quad for code %0d", rsp_glyph_code);
            failures++;
         end else begin
            quad_type e;
            e = pending_quads.pop_front();
            if (rsp_glyph_code !== e.code) begin
               $error("glyph_code exp %h got %h", e.code, rsp_glyph_code); failures++; end
            if (rsp_left_x !== e.lx) begin
               $error("left_x exp %h got %h", e.lx, rsp_left_x); failures++; end
            if (rsp_right_x !== e.rx) begin
               $error("right_x exp %h got %h", e.rx, rsp_right_x); failures++; end
            if (rsp_top_y !== e.ty) begin
               $error("top_y exp %h got %h", e.ty, rsp_top_y); failures++; end
            if (rsp_bottom_y !== e.by) begin
               $error("bottom_y exp %h got %h", e.by, rsp_bottom_y); failures++; end
            if (rsp_u_left !== e.ul) begin
               $error("u_left exp %h got %h", e.ul, rsp_u_left); failures++; end
            if (rsp_u_right !== e.ur) begin
               $error("u_right exp %h got %h", e.ur, rsp_u_right); failures++; end
            if (rsp_v_top !== e.vt) begin
               $error("v_top exp %h got %h", e.vt, rsp_v_top); failures++; end
            if (rsp_v_bottom !== e.vb) begin
               $error("v_bottom exp %h got %h", e.vb, rsp_v_bottom); failures++; end
            if (rsp_quad_color !== e.color) begin
               $error("quad_color exp %h got %h", e.color, rsp_quad_color); failures++; end
         end
      end
   end

   // send one command: idle a random gap, raise start, hold until accepted
   task automatic send_command(gqtl_pkg::cmd_type cmd, logic [7:0] code,
                               logic [11:0] ax = 0, ay = 0, cw = 0, ch = 1, adv = 0,
                               logic [15:0] sx = 0, sy = 0);
      repeat ($urandom_range(0, 6)) @(negedge clock);
      req_command = cmd; req_char_code = code;
      req_atlas_x = ax; req_atlas_y = ay; req_cell_width = cw;
      req_cell_height = ch; req_advance_texels = adv;
      req_start_x = sx; req_start_y = sy;
      start = 1;
      do @(posedge clock); while (busy);
      predict_layout(cmd, code, ax, ay, cw, ch, adv, sx, sy);
      @(negedge clock);
      start = 0;
   endtask

   task automatic send_load(logic [7:0] code);
      send_command(gqtl_pkg::CMD_LOAD, code, 12'($urandom), 12'($urandom), 12'($urandom),
                   12'($urandom), 12'($urandom));
   endtask

   // drain, then let an unanswered place finish before touching registers
   task automatic wait_idle();
      while (pending_quads.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(gqtl_pkg::reg_type idx, logic [31:0] value);
      csr_index = idx; csr_data = value; csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gqtl_pkg::REG_PIXEL_SCALE:    pix_scale = value[15:0];
         gqtl_pkg::REG_TEXT_SCALE:     txt_scale = value[15:0];
         gqtl_pkg::REG_LINE_SPACING:   line_gap = value[15:0];
         gqtl_pkg::REG_TEXTURE_WIDTH:  tex_w = value[12:0];
         gqtl_pkg::REG_TEXTURE_HEIGHT: tex_h = value[12:0];
         default:                      color = value;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic test_directed();
      send_command(gqtl_pkg::CMD_PLACE, 8'd65);             // unknown glyph
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_SPACE); // space with no space glyph
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_TAB);
      send_command(gqtl_pkg::CMD_LOAD, 8'd65, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      send_command(gqtl_pkg::CMD_LOAD, 8'd0, 0, 0, 0, 0, 0);       // zero height
      send_command(gqtl_pkg::CMD_LOAD, gqtl_pkg::CH_SPACE, 1, 2, 3, 7, 12'h0AB);
      send_command(gqtl_pkg::CMD_LOAD, 8'd255, 12'd100, 12'd50, 12'd10, 12'd20, 12'd9);
      send_command(gqtl_pkg::CMD_START, 0, .sx(16'hFFFF), .sy(16'hFFFF));
      send_command(gqtl_pkg::CMD_PLACE, 8'd65);
      send_command(gqtl_pkg::CMD_PLACE, 8'd0);
      send_command(gqtl_pkg::CMD_PLACE, 8'd255);
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_SPACE);
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_TAB);
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_NEWLINE);
      send_command(gqtl_pkg::CMD_NONE, 8'd65);
      send_command(gqtl_pkg::CMD_START, 0, .sx(0), .sy(0));
      send_command(gqtl_pkg::CMD_PLACE, 8'd255);
      wait_idle();
   endtask

   task automatic test_registers();
      write_reg(gqtl_pkg::REG_PIXEL_SCALE, 32'hFFFF);
      write_reg(gqtl_pkg::REG_TEXT_SCALE, 32'hFFFF);
      write_reg(gqtl_pkg::REG_LINE_SPACING, 32'hFFFF);
      write_reg(gqtl_pkg::REG_TEXTURE_WIDTH, 0);
      write_reg(gqtl_pkg::REG_TEXTURE_HEIGHT, 13'h1FFF);
      write_reg(gqtl_pkg::REG_TEXT_COLOR, 0);
      send_command(gqtl_pkg::CMD_PLACE, 8'd65);
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_NEWLINE);
      send_command(gqtl_pkg::CMD_PLACE, 8'd0);
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_SPACE);
      wait_idle();
      write_reg(gqtl_pkg::REG_PIXEL_SCALE, 0);
      write_reg(gqtl_pkg::REG_TEXT_SCALE, 0);
      write_reg(gqtl_pkg::REG_LINE_SPACING, 0);
      write_reg(gqtl_pkg::REG_TEXTURE_WIDTH, 1);
      write_reg(gqtl_pkg::REG_TEXTURE_HEIGHT, 4096);
      write_reg(gqtl_pkg::REG_TEXT_COLOR, 32'hA5A5_5A5A);
      send_command(gqtl_pkg::CMD_PLACE, 8'd255);
      send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_NEWLINE);
      wait_idle();
   endtask

   // phases of random text under random settings; mostly loaded glyphs
   task automatic test_random_text();
      logic [7:0] code;
      for (int phase = 0; phase < 7; phase++) begin
         write_reg(gqtl_pkg::REG_PIXEL_SCALE,
                   $urandom_range(0, 3) == 0 ? 32'($urandom) : $urandom_range(256, 8192));
         write_reg(gqtl_pkg::REG_TEXT_SCALE,
                   $urandom_range(0, 3) == 0 ? 32'($urandom) : $urandom_range(64, 1024));
         write_reg(gqtl_pkg::REG_LINE_SPACING, $urandom);
         write_reg(gqtl_pkg::REG_TEXTURE_WIDTH, $urandom_range(0, 8191));
         write_reg(gqtl_pkg::REG_TEXTURE_HEIGHT, $urandom_range(1, 4096));
         write_reg(gqtl_pkg::REG_TEXT_COLOR, $urandom);
         for (int n = 0; n < 200; n++) begin
            case ($urandom_range(0, 19))
               0, 1:    send_load(8'($urandom));
               2:       send_command(gqtl_pkg::CMD_START, 0, .sx(16'($urandom)),
                                     .sy(16'($urandom)));
               3:       send_command(gqtl_pkg::CMD_NONE, 8'($urandom), 12'($urandom),
                                     12'($urandom));
               4:       send_command(gqtl_pkg::CMD_PLACE, gqtl_pkg::CH_NEWLINE);
               5, 6:    send_command(gqtl_pkg::CMD_PLACE, $urandom_range(0, 1) ?
                                     gqtl_pkg::CH_SPACE : gqtl_pkg::CH_TAB);
               7:       send_command(gqtl_pkg::CMD_PLACE, 8'($urandom));
               default: begin
                  code = 8'($urandom_range(33, 40));
                  if (!atlas[code].ok) send_load(code);
                  send_command(gqtl_pkg::CMD_PLACE, code);
               end
            endcase
         end
         wait_idle();
      end
   endtask

   initial begin
      pix_scale = 4096; txt_scale = 256; line_gap = 0; tex_w = 256; tex_h = 256;
      color = '1; pen_x = 0; pen_y = 0;
      foreach (atlas[i]) atlas[i].ok = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_registers();
      test_random_text();
      wait_idle();
      if (failures == 0 && pending_quads.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
